[rtl/core/hfd_pkg.sv]
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared widths, codes and control types of the half-band decimator.
// ----------------------------------------------------------------------------
package hfd_pkg;

    localparam int DATA_W        = 24;
    localparam int COEF_W        = 18;
    localparam int IDX_W         = 4;
    localparam int PAIR_TAPS_DEF = 8;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 24;
    localparam int FRAC_W        = 17;

    localparam logic MODE_PAIR = 1'b0;
    localparam logic MODE_COEF = 1'b1;

    typedef struct packed {
        logic load_coef;
        logic load_pair;
        logic issue;
        logic center;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

[rtl/core/hfd_ctrl.sv]
// ----------------------------------------------------------------------------
// hfd_ctrl
// Sequencer: accepts items, steps the shared multiply-accumulate over the
// pairs and the center tap, flushes the pipeline and loads the result.
// ----------------------------------------------------------------------------
module hfd_ctrl #(
    parameter int PAIR_TAPS = hfd_pkg::PAIR_TAPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_s_mode,
    output logic          o_s_ready,
    input  hfd_pkg::t_sts i_sts,
    output hfd_pkg::t_cmd o_cmd
);

    localparam int SW = $clog2(PAIR_TAPS + 1);
    localparam logic [SW-1:0] STEP_LAST  = SW'(PAIR_TAPS);
    localparam logic [SW-1:0] FLUSH_LAST = SW'(2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_cnt, n_cnt;
    logic          w_accept;

    assign o_s_ready = (r_state == ST_IDLE);
    assign w_accept  = i_s_valid && o_s_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.load_coef = w_accept && (i_s_mode == hfd_pkg::MODE_COEF);
        o_cmd.load_pair = w_accept && (i_s_mode == hfd_pkg::MODE_PAIR);
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load_pair) begin
                    n_state = ST_ISSUE;
                    n_cnt   = '0;
                end
            end
            ST_ISSUE: begin
                o_cmd.issue  = 1'b1;
                o_cmd.center = (r_cnt == STEP_LAST);
                if (r_cnt == STEP_LAST) begin
                    n_state = ST_FLUSH;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + SW'(1);
                end
            end
            ST_FLUSH: begin
                if (r_cnt == FLUSH_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + SW'(1);
                end
            end
            ST_DONE: begin
                o_cmd.emit = !i_sts.out_busy;
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("result loaded over a pending result");

    a_pair_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_pair |=> (r_state == ST_ISSUE && r_cnt == '0))
        else $error("pair item did not start the step sequence");

    a_center_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_cnt == '0) |-> $past(o_cmd.center))
        else $error("flush entered without a center tap step");

endmodule

[rtl/core/hfd_dp.sv]
// ----------------------------------------------------------------------------
// hfd_dp
// Datapath: sample history, odd ring, coefficients, shared pre-add multiply-
// accumulate pipeline, rounding, saturation and output register.
// ----------------------------------------------------------------------------
module hfd_dp #(
    parameter int PAIR_TAPS = hfd_pkg::PAIR_TAPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hfd_pkg::t_cmd                        i_cmd,
    output hfd_pkg::t_sts                        o_sts,
    input  logic signed [hfd_pkg::DATA_W-1:0]    i_even_sample,
    input  logic signed [hfd_pkg::DATA_W-1:0]    i_odd_sample,
    input  logic        [hfd_pkg::IDX_W-1:0]     i_coef_index,
    input  logic signed [hfd_pkg::COEF_W-1:0]    i_coef_value,
    input  logic                                 i_m_ready,
    output logic                                 o_m_valid,
    output logic signed [hfd_pkg::DATA_W-1:0]    o_out_sample
);

    localparam int DW     = hfd_pkg::DATA_W;
    localparam int CFW    = hfd_pkg::COEF_W;
    localparam int HD     = 2 * PAIR_TAPS;
    localparam int HW     = $clog2(HD);
    localparam int RW     = $clog2(PAIR_TAPS);
    localparam int PRE_W  = DW + 1;
    localparam int PROD_W = PRE_W + CFW;
    localparam int ACC_W  = PROD_W + $clog2(PAIR_TAPS + 1);
    localparam int CMP_W  = 8;

    localparam logic [HW-1:0] HLAST = HW'(HD - 1);
    localparam logic [RW-1:0] RLAST = RW'(PAIR_TAPS - 1);
    localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) <<< (hfd_pkg::FRAC_W - 1);
    localparam logic signed [ACC_W:0] SAT_MAX  = (ACC_W + 1)'((1 << (DW - 1)) - 1);
    localparam logic signed [ACC_W:0] SAT_MIN  = -((ACC_W + 1)'(1) <<< (DW - 1));

    // sample history and odd ring storage
    logic signed [DW-1:0] r_hist [HD];
    logic signed [DW-1:0] r_ring [PAIR_TAPS];
    logic [HD-1:0]        r_hvld;
    logic [PAIR_TAPS-1:0] r_rvld;
    logic [HW-1:0]        r_wp, r_pa, r_pb;
    logic [RW-1:0]        r_rp;

    logic signed [DW-1:0]  r_ha, r_hb, r_od;
    logic                  r_ha_ok, r_hb_ok, r_od_ok;

    logic signed [CFW-1:0] r_outer [PAIR_TAPS];
    logic signed [CFW-1:0] r_center;
    logic [RW-1:0]         r_ci;

    logic signed [CFW-1:0]   r_c1, r_c2;
    logic                    r_ctr1;
    logic signed [PRE_W-1:0] r_pre;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_v1, r_v2, r_v3;
    logic signed [ACC_W-1:0] r_acc;

    logic                    r_out_v;
    logic signed [DW-1:0]    r_out;

    logic signed [PRE_W-1:0] w_ha_x, w_hb_x, w_od_x;
    logic signed [ACC_W:0]   w_rnd;
    logic signed [DW-1:0]    w_sat;
    logic                    w_is_outer, w_is_center;

    assign w_is_outer  = (CMP_W'(i_coef_index) < CMP_W'(PAIR_TAPS));
    assign w_is_center = (CMP_W'(i_coef_index) == CMP_W'(PAIR_TAPS));

    // memories: write on a pair item, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pair) begin
            r_hist[r_wp] <= i_even_sample;
            r_ring[r_rp] <= i_odd_sample;
            r_od         <= r_ring[r_rp];
            r_od_ok      <= r_rvld[r_rp];
        end
        r_ha    <= r_hist[r_pa];
        r_hb    <= r_hist[r_pb];
        r_ha_ok <= r_hvld[r_pa];
        r_hb_ok <= r_hvld[r_pb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld <= '0;
            r_rvld <= '0;
            r_wp   <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_rp   <= '0;
        end else begin
            if (i_cmd.load_pair) begin
                r_hvld[r_wp] <= 1'b1;
                r_rvld[r_rp] <= 1'b1;
                r_pa <= (r_wp == HLAST) ? '0 : r_wp + HW'(1);
                r_pb <= r_wp;
                r_wp <= (r_wp == HLAST) ? '0 : r_wp + HW'(1);
                r_rp <= (r_rp == '0) ? RLAST : r_rp - RW'(1);
            end else if (i_cmd.issue) begin
                r_pa <= (r_pa == HLAST) ? '0 : r_pa + HW'(1);
                r_pb <= (r_pb == '0) ? HLAST : r_pb - HW'(1);
            end
        end
    end

    // coefficients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAIR_TAPS; k++) begin
                r_outer[k] <= '0;
            end
            r_center <= '0;
        end else if (i_cmd.load_coef) begin
            if (w_is_outer) begin
                r_outer[RW'(i_coef_index)] <= i_coef_value;
            end else if (w_is_center) begin
                r_center <= i_coef_value;
            end
        end
    end

    // shared pre-add multiply-accumulate pipeline
    assign w_ha_x = r_ha_ok ? PRE_W'(r_ha) : '0;
    assign w_hb_x = r_hb_ok ? PRE_W'(r_hb) : '0;
    assign w_od_x = r_od_ok ? PRE_W'(r_od) : '0;

    always_ff @(posedge i_clk) begin
        r_c1   <= i_cmd.center ? r_center : r_outer[r_ci];
        r_ctr1 <= i_cmd.center;
        r_pre  <= r_ctr1 ? w_od_x : w_ha_x + w_hb_x;
        r_c2   <= r_c1;
        r_prod <= r_pre * r_c2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.load_pair) begin
                r_ci  <= '0;
                r_acc <= '0;
            end else begin
                if (i_cmd.issue && !i_cmd.center) begin
                    r_ci <= r_ci + RW'(1);
                end
                if (r_v3) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
        end
    end

    // round half up, saturate
    assign w_rnd = ((ACC_W + 1)'(r_acc) + RND_HALF) >>> hfd_pkg::FRAC_W;

    always_comb begin
        priority if (w_rnd > SAT_MAX) begin
            w_sat = SAT_MAX[DW-1:0];
        end else if (w_rnd < SAT_MIN) begin
            w_sat = SAT_MIN[DW-1:0];
        end else begin
            w_sat = w_rnd[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_v <= 1'b1;
        end else if (i_m_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_sts.out_busy = r_out_v && !i_m_ready;
    assign o_m_valid      = r_out_v;
    assign o_out_sample   = r_out;

endmodule

[rtl/core/halfband_fir_decimator_x2.sv]
// ----------------------------------------------------------------------------
// halfband_fir_decimator_x2
// Half-band linear-phase FIR decimator by two, polyphase form, fixed point.
// ----------------------------------------------------------------------------
// A sample item (tuser = 0) carries an even/odd pair of 24-bit samples and
// yields one rounded, saturated 24-bit output; a coefficient item (tuser = 1)
// writes one Q1.17 coefficient (index PAIR_TAPS is the center tap) and yields
// nothing. While a sample item occupies the block, one shared pre-add
// multiplier-accumulator takes one mirrored pair per cycle plus a step for the
// center tap, then come a three-stage pipeline flush and the output load. The
// result sits in an output register, so the next item is taken while it waits;
// a further result waits in the last state until the previous one has been
// taken.
// ----------------------------------------------------------------------------
module halfband_fir_decimator_x2 #(
    parameter int PAIR_TAPS = hfd_pkg::PAIR_TAPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // even_sample[23:0], odd_sample[47:24], coef_index[51:48],
    // coef_value[69:52], zero fill[71:70]
    input  logic [hfd_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // mode[0]
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_sample[23:0]
    output logic [hfd_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int DW = hfd_pkg::DATA_W;

    hfd_pkg::t_cmd w_cmd;
    hfd_pkg::t_sts w_sts;

    logic signed [DW-1:0]                 w_even_sample;
    logic signed [DW-1:0]                 w_odd_sample;
    logic        [hfd_pkg::IDX_W-1:0]     w_coef_index;
    logic signed [hfd_pkg::COEF_W-1:0]    w_coef_value;
    logic signed [DW-1:0]                 w_out_sample;

    assign w_even_sample = $signed(i_s_axis_tdata[23:0]);
    assign w_odd_sample  = $signed(i_s_axis_tdata[47:24]);
    assign w_coef_index  = i_s_axis_tdata[51:48];
    assign w_coef_value  = $signed(i_s_axis_tdata[69:52]);
    assign o_m_axis_tdata = w_out_sample;

    hfd_ctrl #(
        .PAIR_TAPS (PAIR_TAPS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_mode  (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    hfd_dp #(
        .PAIR_TAPS (PAIR_TAPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_even_sample (w_even_sample),
        .i_odd_sample  (w_odd_sample),
        .i_coef_index  (w_coef_index),
        .i_coef_value  (w_coef_value),
        .i_m_ready     (i_m_axis_tready),
        .o_m_valid     (o_m_axis_tvalid),
        .o_out_sample  (w_out_sample)
    );

endmodule

[test/halfband_fir_decimator_x2_tb.sv]
// ----------------------------------------------------------------------------
// halfband_fir_decimator_x2_tb
// Self-checking bench for the half-band decimator by two.
// ----------------------------------------------------------------------------
// A clocked driver feeds sample-pair and coefficient items from a pending
// queue. A local fixed-point model of the filter predicts each output on
// acceptance. A clocked receiver compares every output with the oldest
// prediction. Both stream sides idle at random, with calm stretches. The
// directed part forces saturation both ways and writes to ignored indices.
// The random part mixes coefficient styles so that exact rounding ties occur.
// ----------------------------------------------------------------------------
module halfband_fir_decimator_x2_tb;

    localparam int   TAPS        = hfd_pkg::PAIR_TAPS_DEF;
    localparam int   DATA_W      = hfd_pkg::DATA_W;
    localparam int   COEF_W      = hfd_pkg::COEF_W;
    localparam int   IDX_W       = hfd_pkg::IDX_W;
    localparam int   S_TDATA_W   = hfd_pkg::S_TDATA_W;
    localparam int   M_TDATA_W   = hfd_pkg::M_TDATA_W;
    localparam int   FRAC_W      = hfd_pkg::FRAC_W;
    localparam logic MODE_PAIR   = hfd_pkg::MODE_PAIR;
    localparam logic MODE_COEF   = hfd_pkg::MODE_COEF;
    localparam int   STALL_LIMIT = 2000;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   SETTLE_CYC  = 40;
    localparam int   N_RANDOM    = 1100;

    typedef struct {
        logic                      mode;
        logic signed [DATA_W-1:0]  even_s;
        logic signed [DATA_W-1:0]  odd_s;
        logic [IDX_W-1:0]          idx;
        logic signed [COEF_W-1:0]  coef;
        bit                        drain;
    } t_hb_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_ready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;

    t_hb_item              pending [$];
    t_hb_item              cur;
    logic [DATA_W-1:0]     expected_outputs [$];

    logic signed [DATA_W-1:0] hist_q [2*TAPS];
    logic signed [DATA_W-1:0] ring_q [TAPS];
    int unsigned              ring_pos;
    logic signed [COEF_W-1:0] outer_q [TAPS];
    logic signed [COEF_W-1:0] center_q;

    int n_items;
    int n_accepted;
    int n_pairs;
    int n_coefs;
    int n_ignored;
    int n_results;
    int n_sat;
    int n_err;
    int send_gap;
    int recv_wait;
    int recv_draw;
    int idle_cycles;
    int n_cycles;

    halfband_fir_decimator_x2 #(
        .PAIR_TAPS (TAPS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic logic [DATA_W-1:0] filter_pair(input logic signed [DATA_W-1:0] ev,
                                                      input logic signed [DATA_W-1:0] od);
        longint acc;
        longint y;
        hist_q[2*TAPS-1] = ev;
        acc = 0;
        for (int j = 0; j < TAPS; j++) begin
            acc += (longint'(hist_q[j]) + longint'(hist_q[2*TAPS-1-j])) * longint'(outer_q[j]);
        end
        acc += longint'(ring_q[ring_pos]) * longint'(center_q);
        ring_q[ring_pos] = od;
        ring_pos = (ring_pos == 0) ? TAPS - 1 : ring_pos - 1;
        for (int j = 0; j < 2*TAPS-1; j++) begin
            hist_q[j] = hist_q[j+1];
        end
        y = (acc + 64'sd65536) >>> FRAC_W;
        if (y > 64'sd8388607) begin
            y = 64'sd8388607;
        end
        if (y < -64'sd8388608) begin
            y = -64'sd8388608;
        end
        return y[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(DATA_W-1){1'b1}}};
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2, 3: return DATA_W'(int'($urandom_range(0, 2000)) - 1000);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(COEF_W-1){1'b1}}};
            1: return {1'b1, {(COEF_W-1){1'b0}}};
            2, 3: return COEF_W'(int'($urandom_range(0, 4096)) - 2048);
            4, 5, 6: return COEF_W'((int'($urandom_range(0, 3)) - 2) * 65536);
            default: return COEF_W'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic mode, input logic [DATA_W-1:0] ev,
                             input logic [DATA_W-1:0] od, input logic [IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] coef, input bit drain);
        t_hb_item it;
        it.mode   = mode;
        it.even_s = ev;
        it.odd_s  = od;
        it.idx    = idx;
        it.coef   = coef;
        it.drain  = drain;
        pending.push_back(it);
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                n_accepted++;
                if (cur.mode == MODE_COEF) begin
                    n_coefs++;
                    if (cur.idx < TAPS) begin
                        outer_q[cur.idx] = cur.coef;
                    end else if (cur.idx == TAPS) begin
                        center_q = cur.coef;
                    end else begin
                        n_ignored++;
                    end
                end else begin
                    n_pairs++;
                    expected_outputs.push_back(filter_pair(cur.even_s, cur.odd_s));
                end
            end
            if (!s_valid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending.size() > 0 &&
                             (!pending[0].drain || expected_outputs.size() == 0)) begin
                    cur = pending.pop_front();
                    s_tdata  <= {2'b00, cur.coef, cur.idx, cur.odd_s, cur.even_s};
                    s_tuser  <= cur.mode;
                    s_valid  <= 1'b1;
                    send_gap <= (((n_accepted >> 7) % 4) == 3) ? 0 : $urandom_range(0, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else if (o_m_axis_tvalid && m_ready) begin
            n_results++;
            if (o_m_axis_tdata == {1'b0, {(DATA_W-1){1'b1}}} ||
                o_m_axis_tdata == {1'b1, {(DATA_W-1){1'b0}}}) begin
                n_sat++;
            end
            if (expected_outputs.size() == 0) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("unexpected output: got %0d", $signed(o_m_axis_tdata));
                end
            end else if (expected_outputs[0] !== o_m_axis_tdata) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("output %0d mismatch: expected %0d, got %0d", n_results,
                             $signed(expected_outputs[0]), $signed(o_m_axis_tdata));
                end
                void'(expected_outputs.pop_front());
            end else begin
                void'(expected_outputs.pop_front());
            end
            recv_draw = (((n_results >> 6) % 4) == 3) ? 0 : $urandom_range(0, 13);
            recv_wait <= recv_draw;
            m_ready   <= (recv_draw == 0);
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            m_ready   <= (recv_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        n_cycles <= n_cycles + 1;
        if (idle_cycles >= STALL_LIMIT || n_cycles >= CYCLE_LIMIT) begin
            $display("stalled with %0d of %0d items accepted", n_accepted, n_items);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [DATA_W-1:0] max_s;
        logic [DATA_W-1:0] min_s;
        logic [COEF_W-1:0] max_c;
        logic [COEF_W-1:0] min_c;
        int                r;
        max_s = {1'b0, {(DATA_W-1){1'b1}}};
        min_s = {1'b1, {(DATA_W-1){1'b0}}};
        max_c = {1'b0, {(COEF_W-1){1'b1}}};
        min_c = {1'b1, {(COEF_W-1){1'b0}}};
        foreach (hist_q[k]) hist_q[k] = '0;
        foreach (ring_q[k]) ring_q[k] = '0;
        foreach (outer_q[k]) outer_q[k] = '0;
        center_q = '0;
        ring_pos = 0;

        // full-scale negative coefficients, then drive to both saturation limits
        for (int k = 0; k <= TAPS; k++) begin
            push_item(MODE_COEF, '0, '0, IDX_W'(k), min_c, 1'b0);
        end
        for (int k = 0; k < 5; k++) begin
            push_item(MODE_PAIR, min_s, min_s, '0, '0, 1'b0);
        end
        for (int k = 0; k < 5; k++) begin
            push_item(MODE_PAIR, max_s, max_s, '1, max_c, 1'b0);
        end
        push_item(MODE_COEF, max_s, min_s, '1, max_c, 1'b0);
        push_item(MODE_COEF, '0, '0, IDX_W'(TAPS + 1), COEF_W'(18'h1abcd), 1'b0);
        push_item(MODE_COEF, '0, '0, IDX_W'(TAPS), max_c, 1'b0);
        push_item(MODE_COEF, '0, '0, '0, '0, 1'b0);
        push_item(MODE_PAIR, '0, max_s, '0, '0, 1'b0);
        push_item(MODE_PAIR, min_s, '0, '0, '0, 1'b0);

        for (int k = 0; k < N_RANDOM; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                push_item(MODE_COEF, DATA_W'($urandom), DATA_W'($urandom),
                          ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, TAPS))
                                                       : IDX_W'($urandom_range(TAPS + 1, 15)),
                          rand_coef(), (k == 0 || k == N_RANDOM / 2));
            end else begin
                push_item(MODE_PAIR, rand_sample(), rand_sample(), IDX_W'($urandom),
                          COEF_W'($urandom), (k == 0 || k == N_RANDOM / 2));
            end
        end
        n_items = pending.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items || expected_outputs.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (expected_outputs.size() > 0) begin
            $display("%0d outputs never arrived", expected_outputs.size());
            n_err += expected_outputs.size();
        end

        $display("sent %0d sample pairs and %0d coefficient writes (%0d to unused indexes)",
                 n_pairs, n_coefs, n_ignored);
        $display("checked %0d outputs, %0d at a saturation limit, %0d errors",
                 n_results, n_sat, n_err);
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
